### sv/bpc_pkg.sv
// bpc_pkg: shared types, constants and time helpers for the button press classifier.
// No dependencies; every other file of the block depends on this package.
package bpc_pkg;

	localparam int TIME_BITS  = 32;   // timestamp arithmetic wraps modulo 2^TIME_BITS
	localparam int TICK_W     = 32;   // width of timestamp and span fields on the ports
	localparam int LVL_W      = 5;
	localparam int TALLY_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [LVL_W-1:0]   LVL_ONE   = LVL_W'(1);
	localparam logic [LVL_W-1:0]   LVL_MIN   = LVL_W'(2);
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TICK_W-1:0]    ticks_t;

	typedef enum logic [2:0] {
		EV_NONE          = 3'd0,
		EV_SHORT         = 3'd1,
		EV_PROC_RESET    = 3'd2,
		EV_FULL_RESET    = 3'd3,
		EV_FACTORY_RESET = 3'd4
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_LEVEL    = 3'd0,
		REG_CLICK_WINDOW      = 3'd1,
		REG_MID_HOLD          = 3'd2,
		REG_LONG_HOLD         = 3'd3,
		REG_RESET_CLICK_COUNT = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [LVL_W-1:0]   debounce_level;
		ticks_t             click_window_ticks;
		ticks_t             mid_hold_ticks;
		ticks_t             long_hold_ticks;
		logic [TALLY_W-1:0] reset_click_count;
	} cfg_t;

	localparam logic [LVL_W-1:0]   RST_DEBOUNCE_LEVEL = LVL_W'(16);
	localparam ticks_t             RST_CLICK_WINDOW   = TICK_W'(16000000);
	localparam ticks_t             RST_MID_HOLD       = TICK_W'(80000000);
	localparam ticks_t             RST_LONG_HOLD      = TICK_W'(160000000);
	localparam logic [TALLY_W-1:0] RST_RESET_CLICKS   = TALLY_W'(5);

	// Port timestamp into the internal time domain (truncate or zero-extend).
	function automatic time_t to_time(input ticks_t t);
		logic [63:0] w;
		w = 64'(t);
		return w[TIME_BITS-1:0];
	endfunction

	// True when more than span ticks have gone by since stamp (wrapped difference).
	function automatic logic span_passed(input time_t now, input time_t stamp,
	                                     input ticks_t span);
		time_t elapsed;
		elapsed = now - stamp;
		return 64'(elapsed) > 64'(span);
	endfunction

endpackage

### sv/bpc_ifs.sv
// bpc_ifs: valid/ready channel interfaces for request, result and configuration beats.
// Depends on bpc_pkg for field widths.
interface bpc_req_if;
	logic                  valid;
	logic                  ready;
	logic                  pin_level;
	logic [bpc_pkg::TICK_W-1:0] now_ticks;
	modport source(output valid, pin_level, now_ticks, input ready);
	modport sink(input valid, pin_level, now_ticks, output ready);
endinterface

interface bpc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic       busy_res;
	modport source(output valid, event_res, busy_res, input ready);
	modport sink(input valid, event_res, busy_res, output ready);
endinterface

interface bpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bpc_pkg::CFG_IDX_W-1:0]  index;
	logic [bpc_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### sv/bpc_cfg_regs.sv
// bpc_cfg_regs: configuration register file, one write beat per cycle.
// Depends on bpc_pkg (cfg_t, register index codes, reset values).
module bpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] wr_data,
	output bpc_pkg::cfg_t                  cfg
);
	import bpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_level     <= RST_DEBOUNCE_LEVEL;
			cfg_q.click_window_ticks <= RST_CLICK_WINDOW;
			cfg_q.mid_hold_ticks     <= RST_MID_HOLD;
			cfg_q.long_hold_ticks    <= RST_LONG_HOLD;
			cfg_q.reset_click_count  <= RST_RESET_CLICKS;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				REG_DEBOUNCE_LEVEL:    cfg_q.debounce_level     <= wr_data[LVL_W-1:0];
				REG_CLICK_WINDOW:      cfg_q.click_window_ticks <= wr_data[TICK_W-1:0];
				REG_MID_HOLD:          cfg_q.mid_hold_ticks     <= wr_data[TICK_W-1:0];
				REG_LONG_HOLD:         cfg_q.long_hold_ticks    <= wr_data[TICK_W-1:0];
				REG_RESET_CLICK_COUNT: cfg_q.reset_click_count  <= wr_data[TALLY_W-1:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/bpc_step_logic.sv
// bpc_step_logic: debounce integrator, press/release state and event classification.
// Depends on bpc_pkg; one poll is folded into the state per enabled cycle.
module bpc_step_logic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic                 pin_level,
	input  bpc_pkg::ticks_t      now_ticks,
	input  bpc_pkg::cfg_t        cfg,
	output bpc_pkg::event_t      event_res,
	output logic                 busy_res
);
	import bpc_pkg::*;

	logic [LVL_W-1:0]   integ_q,   integ_d;
	logic               held_q,    held_d;
	time_t              press_q,   press_d;
	time_t              rel_q,     rel_d;
	logic [TALLY_W-1:0] tally_q,   tally_d;

	logic [LVL_W-1:0] top;
	logic             pressed;
	logic             let_go;
	logic             win_passed;
	time_t            now_t;
	event_t           ev;

	assign now_t      = to_time(now_ticks);
	assign pressed    = ~pin_level;
	assign top        = (cfg.debounce_level < LVL_MIN) ? LVL_MIN : cfg.debounce_level;
	// release stamp only moves on a release, which never reaches the window check
	assign win_passed = span_passed(now_t, rel_q, cfg.click_window_ticks);

	always_comb begin
		integ_d = integ_q;
		held_d  = held_q;
		press_d = press_q;
		rel_d   = rel_q;
		tally_d = tally_q;
		let_go  = 1'b0;
		ev      = EV_NONE;

		if (pressed) begin
			if (integ_q < top) begin
				integ_d = integ_q + LVL_ONE;
				if (integ_d == top) begin
					held_d  = 1'b1;
					press_d = now_t;
					if (!win_passed) begin
						if (tally_q != TALLY_MAX)
							tally_d = tally_q + TALLY_W'(1);
					end else begin
						tally_d = TALLY_W'(1);
					end
				end
			end
		end else if (integ_q != LVL_ONE) begin
			integ_d = integ_q - LVL_ONE;
			if (integ_d == LVL_ONE && held_q) begin
				let_go = 1'b1;
				rel_d  = now_t;
			end
		end

		if (held_d && let_go) begin
			held_d = 1'b0;
			if (span_passed(now_t, press_q, cfg.long_hold_ticks))
				ev = EV_FULL_RESET;
			else if (span_passed(now_t, press_q, cfg.mid_hold_ticks))
				ev = EV_PROC_RESET;
			else
				ev = EV_SHORT;
		end else if (!held_d && win_passed) begin
			if (tally_d != '0 && tally_d == cfg.reset_click_count)
				ev = EV_FACTORY_RESET;
			tally_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= LVL_ONE;
			held_q  <= 1'b0;
			press_q <= '0;
			rel_q   <= '0;
			tally_q <= '0;
		end else if (step_en) begin
			integ_q <= integ_d;
			held_q  <= held_d;
			press_q <= press_d;
			rel_q   <= rel_d;
			tally_q <= tally_d;
		end
	end

	assign event_res = ev;
	assign busy_res  = (integ_d != LVL_ONE && integ_d != top) || held_d || (tally_d != '0);

`ifndef SYNTHESIS
	// integrator never underflows past its floor
	a_integ_floor: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q != '0)
		else $error("integrator reached zero");

	// a held button always has at least one click on the tally
	a_held_tally: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> tally_q != '0)
		else $error("held with empty click tally");

	// hold classes only come from a press that was registered
	a_release_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (ev == EV_SHORT || ev == EV_PROC_RESET || ev == EV_FULL_RESET)
		|-> held_q)
		else $error("release event without a held press");
`endif

endmodule

### sv/button_press_classifier_core.sv
// button_press_classifier_core: top level of the debounced button classifier.
// Depends on bpc_pkg, bpc_ifs, bpc_cfg_regs and bpc_step_logic.
//
// One request beat is one poll of the active-low button pin with a free-running
// timestamp; every poll produces exactly one result beat carrying an event code
// (none, short press, processor reset, full reset, factory reset) and a busy flag.
// A poll is registered at the input (_s1), folded into the debounce and click
// state as it moves on from _s1, and the outcome lands in the result register
// (_s2). One poll is taken every cycle while the result side does not stall,
// the rate being set by the state update of integrator, stamps and click
// tally. The input register keeps taking beats while a result waits to be
// taken, so a stall on the result side only reaches the request side once both
// registers are full. Configuration beats are always accepted and should be sent
// only while no poll is in flight; register indexes above the last one are ignored.
module button_press_classifier_core (
	input  logic         clk,
	input  logic         arst_n,
	bpc_req_if.sink      req,
	bpc_rsp_if.source    rsp,
	bpc_cfg_if.sink      cfg
);
	import bpc_pkg::*;

	// input register
	logic   valid_s1;
	logic   pin_s1;
	ticks_t now_s1;

	// result register
	logic   valid_s2;
	event_t event_s2;
	logic   busy_s2;

	logic   adv_s1;     // poll in _s1 moves into the result register
	event_t step_event;
	logic   step_busy;
	cfg_t   cfg_cur;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	bpc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_cur)
	);

	bpc_step_logic u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv_s1),
		.pin_level (pin_s1),
		.now_ticks (now_s1),
		.cfg       (cfg_cur),
		.event_res (step_event),
		.busy_res  (step_busy)
	);

	// input stage: valid is control, payload loads with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			pin_s1 <= req.pin_level;
			now_s1 <= req.now_ticks;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			event_s2 <= step_event;
			busy_s2  <= step_busy;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.event_res = event_s2;
	assign rsp.busy_res  = busy_s2;

`ifndef SYNTHESIS
	// both stages full and the result stalled: no new request may enter
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp.ready |-> !req.ready)
		else $error("request taken while pipeline is blocked");

	// every beat leaving _s1 appears in the result register on the next edge
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("advanced poll lost before the result register");

	// an empty input stage never advances a poll into the state
	a_no_phantom_step: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !adv_s1)
		else $error("state stepped without a poll");
`endif

endmodule
